// ===== hdl/tmpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmpm_pkg
// Types and fixed constants of the tiered motor protection monitor.
// ----------------------------------------------------------------------------
package tmpm_pkg;

   localparam int unsigned SampleW    = 12;
   localparam int unsigned AvgDepth   = 4;
   localparam int unsigned AvgShift   = $clog2(AvgDepth);
   localparam int unsigned SlotW      = $clog2(AvgDepth);
   localparam int unsigned SumW       = SampleW + AvgShift;
   localparam int unsigned CountW     = 32;
   localparam int unsigned DelayW     = 16;
   localparam int unsigned HotW       = 3;
   localparam int unsigned TierCount  = 4;
   localparam int unsigned FlagCount  = 7;
   localparam int unsigned CsrIndexW  = 3;

   localparam logic [CountW-1:0] ManageStep   = CountW'(2);
   localparam logic [CountW-1:0] ReloadValue  = CountW'(2);
   localparam logic [CountW-1:0] CountIdle    = '1;
   localparam logic [HotW-1:0]   HotConfirm   = HotW'(3);
   localparam logic [HotW-1:0]   HotMax       = '1;
   localparam logic [SampleW-1:0] LimitTop    = '1;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_MANAGE = 1'b1
   } op_type;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_VOLT_LOW    = 3'd0,
      CSR_CUR_ONE     = 3'd1,
      CSR_CUR_TWO     = 3'd2,
      CSR_CUR_THREE   = 3'd3,
      CSR_CUR_FOUR    = 3'd4,
      CSR_CUR_SHORT   = 3'd5,
      CSR_TEMP_TRIP   = 3'd6,
      CSR_UNUSED      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                 over_temp;
      logic                 short_circuit;
      logic [TierCount-1:0] tiers;
      logic                 low_volt;
   } fault_type;

   typedef logic [SampleW-1:0] window_type [AvgDepth];

endpackage : tmpm_pkg
`default_nettype wire

// ===== hdl/tiered_motor_protection_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tiered_motor_protection_monitor
// Moving-average fault detection with a tiered protection countdown.
// ----------------------------------------------------------------------------
// A request is taken into an input register; once the result register is free,
// one pass updates the three four-sample averaging windows, fault flags and
// over-temperature run count (sample requests) and the protection countdown,
// and loads the result register. One request per clock is sustained unless
// stalled; a request passes the input and then the result register. The pass
// (window sums, limit compares, delay minimum, 32-bit compares) sets the clock
// period. A result held under stall keeps the input register full and so
// stalls requests in the same cycle. The user must write limit registers via
// the csr port only while the block is idle, not enforced; index 7 is ignored.
module tiered_motor_protection_monitor
   import tmpm_pkg::*;
#(
   parameter int unsigned DELAY_TIER_ONE   = 3000,
   parameter int unsigned DELAY_TIER_TWO   = 600,
   parameter int unsigned DELAY_TIER_THREE = 100,
   parameter int unsigned DELAY_TIER_FOUR  = 20,
   parameter int unsigned DELAY_SHORT      = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // configuration
   input  wire logic                 csr_write_en,
   input  wire logic [CsrIndexW-1:0] csr_index,
   input  wire logic [SampleW-1:0]   csr_data,
   // requests
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic                 req_op,
   input  wire logic [SampleW-1:0]   req_volt_sample,
   input  wire logic [SampleW-1:0]   req_current_sample,
   input  wire logic [SampleW-1:0]   req_temp_sample,
   // results
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic                 rsp_low_volt_flag,
   output      logic [TierCount-1:0] rsp_over_cur_tiers,
   output      logic                 rsp_short_flag,
   output      logic                 rsp_over_temp_flag,
   output      logic [CountW-1:0]    rsp_protect_countdown,
   output      logic                 rsp_stop_request
);

   localparam logic [DelayW-1:0] DelayOne   = DelayW'(DELAY_TIER_ONE);
   localparam logic [DelayW-1:0] DelayTwo   = DelayW'(DELAY_TIER_TWO);
   localparam logic [DelayW-1:0] DelayThree = DelayW'(DELAY_TIER_THREE);
   localparam logic [DelayW-1:0] DelayFour  = DelayW'(DELAY_TIER_FOUR);
   localparam logic [DelayW-1:0] DelayShort = DelayW'(DELAY_SHORT);

   // limit registers
   logic [SampleW-1:0] volt_low_ff, cur_one_ff, cur_two_ff, cur_three_ff;
   logic [SampleW-1:0] cur_four_ff, cur_short_ff, temp_trip_ff;

   // input register
   logic               in_valid_ff;
   op_type             in_op_ff;
   logic [SampleW-1:0] in_volt_ff, in_cur_ff, in_temp_ff;

   // monitor state
   window_type         volt_win_ff, cur_win_ff, temp_win_ff;
   window_type         volt_win_in, cur_win_in, temp_win_in;
   logic [SlotW-1:0]   slot_ff, slot_in;
   logic               primed_ff;
   fault_type          flags_ff, flags_in;
   logic [HotW-1:0]    hot_cnt_ff, hot_cnt_in;
   logic [CountW-1:0]  countdown_ff, countdown_in;
   logic [CountW-1:0]  held_ff, held_in;
   logic               stop_in;

   // result register
   logic               out_valid_ff;
   fault_type          out_flags_ff;
   logic [CountW-1:0]  out_count_ff;
   logic               out_stop_ff;

   logic               advance;
   logic [SumW-1:0]    volt_sum, cur_sum, temp_sum;
   logic [SampleW-1:0] volt_avg, cur_avg, temp_avg;
   logic [DelayW-1:0]  delay_min;
   logic               any_trip;
   logic [CountW-1:0]  count_base;
   logic [CountW-1:0]  count_dec;
   logic [CountW-1:0]  delay_wide;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         volt_low_ff  <= '0;
         cur_one_ff   <= LimitTop;
         cur_two_ff   <= LimitTop;
         cur_three_ff <= LimitTop;
         cur_four_ff  <= LimitTop;
         cur_short_ff <= LimitTop;
         temp_trip_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_VOLT_LOW:  volt_low_ff  <= csr_data;
            CSR_CUR_ONE:   cur_one_ff   <= csr_data;
            CSR_CUR_TWO:   cur_two_ff   <= csr_data;
            CSR_CUR_THREE: cur_three_ff <= csr_data;
            CSR_CUR_FOUR:  cur_four_ff  <= csr_data;
            CSR_CUR_SHORT: cur_short_ff <= csr_data;
            CSR_TEMP_TRIP: temp_trip_ff <= csr_data;
            CSR_UNUSED: ;
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------- input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_op_ff   <= op_type'(req_op);
         in_volt_ff <= req_volt_sample;
         in_cur_ff  <= req_current_sample;
         in_temp_ff <= req_temp_sample;
      end
   end

   // --------------------------------------------------------------- windows
   always_comb begin
      volt_win_in = volt_win_ff;
      cur_win_in  = cur_win_ff;
      temp_win_in = temp_win_ff;
      if (!primed_ff) begin
         // first sample fills every slot
         for (int i = 0; i < AvgDepth; i++) begin
            volt_win_in[i] = in_volt_ff;
            cur_win_in[i]  = in_cur_ff;
            temp_win_in[i] = in_temp_ff;
         end
      end else begin
         volt_win_in[slot_ff] = in_volt_ff;
         cur_win_in[slot_ff]  = in_cur_ff;
         temp_win_in[slot_ff] = in_temp_ff;
      end
   end

   always_comb begin
      volt_sum = '0;
      cur_sum  = '0;
      temp_sum = '0;
      for (int i = 0; i < AvgDepth; i++) begin
         volt_sum = volt_sum + SumW'(volt_win_in[i]);
         cur_sum  = cur_sum  + SumW'(cur_win_in[i]);
         temp_sum = temp_sum + SumW'(temp_win_in[i]);
      end
   end

   assign volt_avg = volt_sum[SumW-1:AvgShift];
   assign cur_avg  = cur_sum[SumW-1:AvgShift];
   assign temp_avg = temp_sum[SumW-1:AvgShift];

   assign slot_in = primed_ff ? slot_ff + SlotW'(1) : slot_ff;

   // ------------------------------------------------------------ fault logic
   always_comb begin
      flags_in               = '0;
      flags_in.low_volt      = volt_avg < volt_low_ff;
      flags_in.tiers[0]      = cur_avg > cur_one_ff;
      flags_in.tiers[1]      = cur_avg > cur_two_ff;
      flags_in.tiers[2]      = cur_avg > cur_three_ff;
      flags_in.tiers[3]      = cur_avg > cur_four_ff;
      flags_in.short_circuit = cur_avg > cur_short_ff;
      if (temp_avg < temp_trip_ff) begin
         flags_in.over_temp = (hot_cnt_ff > HotConfirm) ? 1'b1 : flags_ff.over_temp;
         hot_cnt_in = (hot_cnt_ff == HotMax) ? hot_cnt_ff : hot_cnt_ff + HotW'(1);
      end else begin
         flags_in.over_temp = 1'b0;
         hot_cnt_in = '0;
      end
   end

   // smallest delay among the tripped levels, kept at delay width
   always_comb begin
      delay_min = '1;
      if (flags_in.low_volt && DelayThree < delay_min) delay_min = DelayThree;
      if (flags_in.tiers[0] && DelayOne < delay_min)   delay_min = DelayOne;
      if (flags_in.tiers[1] && DelayTwo < delay_min)   delay_min = DelayTwo;
      if (flags_in.tiers[2] && DelayThree < delay_min) delay_min = DelayThree;
      if (flags_in.tiers[3] && DelayFour < delay_min)  delay_min = DelayFour;
      if (flags_in.short_circuit && DelayShort < delay_min) delay_min = DelayShort;
   end

   // low voltage mins against the live countdown, otherwise the held value
   assign any_trip   = flags_in.low_volt || (|flags_in.tiers) || flags_in.short_circuit;
   assign count_base = flags_in.low_volt ? countdown_ff : held_ff;
   assign delay_wide = CountW'(delay_min);
   assign count_dec  = countdown_ff - ManageStep;

   always_comb begin
      countdown_in = countdown_ff;
      held_in      = held_ff;
      stop_in      = 1'b0;
      unique case (in_op_ff)
         OP_SAMPLE: begin
            countdown_in = (any_trip && delay_wide < count_base) ? delay_wide : count_base;
            held_in      = countdown_in;
         end
         OP_MANAGE: begin
            if (count_dec == '0) begin
               countdown_in = ReloadValue;
               stop_in      = 1'b1;
            end else begin
               countdown_in = count_dec;
            end
            if (flags_ff != '0) stop_in = 1'b1;
         end
         default: ;
      endcase
   end

   // ----------------------------------------------------------- state update
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         primed_ff    <= 1'b0;
         flags_ff     <= '0;
         hot_cnt_ff   <= '0;
         countdown_ff <= CountIdle;
         held_ff      <= CountIdle;
         for (int i = 0; i < AvgDepth; i++) begin
            volt_win_ff[i] <= '0;
            cur_win_ff[i]  <= '0;
            temp_win_ff[i] <= '0;
         end
      end else if (advance) begin
         countdown_ff <= countdown_in;
         held_ff      <= held_in;
         if (in_op_ff == OP_SAMPLE) begin
            volt_win_ff <= volt_win_in;
            cur_win_ff  <= cur_win_in;
            temp_win_ff <= temp_win_in;
            slot_ff     <= slot_in;
            primed_ff   <= 1'b1;
            flags_ff    <= flags_in;
            hot_cnt_ff  <= hot_cnt_in;
         end
      end
   end

   // --------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_flags_ff <= (in_op_ff == OP_SAMPLE) ? flags_in : flags_ff;
         out_count_ff <= countdown_in;
         out_stop_ff  <= stop_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_low_volt_flag     = out_flags_ff.low_volt;
   assign rsp_over_cur_tiers    = out_flags_ff.tiers;
   assign rsp_short_flag        = out_flags_ff.short_circuit;
   assign rsp_over_temp_flag    = out_flags_ff.over_temp;
   assign rsp_protect_countdown = out_count_ff;
   assign rsp_stop_request      = out_stop_ff;

   // ------------------------------------------------------------- assertions
   // the countdown reloads before it can reach zero
   assert property (@(posedge clock) disable iff (reset) countdown_ff != '0)
      else $error("protection countdown reached zero");

   // a sample request leaves the held value equal to the countdown
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff == OP_SAMPLE) |=> (held_ff == countdown_ff))
      else $error("held countdown out of step after sample");

   // over temperature only after five low readings in a row
   assert property (@(posedge clock) disable iff (reset)
      flags_ff.over_temp |-> (hot_cnt_ff > HotConfirm + HotW'(1)))
      else $error("over temperature flag without a confirmed run");

   // a result waiting under stall is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !advance)
      else $error("result register overwritten while stalled");

endmodule : tiered_motor_protection_monitor
`default_nettype wire

// ===== bench/tmpm_protection_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmpm_protection_checker
// Watches the limit writes, requests and results of the protection monitor,
// keeps its own copy of the averaging windows, fault flags and countdown,
// and compares every result with the report it predicts for the request.
// ----------------------------------------------------------------------------
module tmpm_protection_checker
   import tmpm_pkg::*;
#(
   parameter int unsigned DELAY_TIER_ONE   = 3000,
   parameter int unsigned DELAY_TIER_TWO   = 600,
   parameter int unsigned DELAY_TIER_THREE = 100,
   parameter int unsigned DELAY_TIER_FOUR  = 20,
   parameter int unsigned DELAY_SHORT      = 10
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_en,
   input  wire logic [CsrIndexW-1:0] csr_index,
   input  wire logic [SampleW-1:0]   csr_data,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic                 req_op,
   input  wire logic [SampleW-1:0]   req_volt_sample,
   input  wire logic [SampleW-1:0]   req_current_sample,
   input  wire logic [SampleW-1:0]   req_temp_sample,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic                 rsp_low_volt_flag,
   input  wire logic [TierCount-1:0] rsp_over_cur_tiers,
   input  wire logic                 rsp_short_flag,
   input  wire logic                 rsp_over_temp_flag,
   input  wire logic [CountW-1:0]    rsp_protect_countdown,
   input  wire logic                 rsp_stop_request,
   output int                        mismatch_count,
   output int                        pending_results,
   output int                        results_checked
);

   typedef struct packed {
      logic                 low_volt;
      logic [TierCount-1:0] tiers;
      logic                 short_circuit;
      logic                 over_temp;
      logic [CountW-1:0]    countdown;
      logic                 stop;
   } monitor_report_type;

   window_type         volt_win;
   window_type         amps_win;
   window_type         temp_win;
   logic [SlotW-1:0]   slot;
   logic               primed;
   fault_type          faults;
   logic [HotW-1:0]    hot_run;
   logic [CountW-1:0]  countdown;
   logic [CountW-1:0]  held_countdown;
   logic [SampleW-1:0] limit_reg [FlagCount];
   int                 errors = 0;
   int                 checked = 0;
   monitor_report_type awaited_reports [$];

   function automatic logic [SampleW-1:0] window_mean(input window_type w);
      logic [SumW-1:0] total;
      total = '0;
      foreach (w[i]) total += SumW'(w[i]);
      return SampleW'(total >> AvgShift);
   endfunction

   function automatic monitor_report_type predict_protection(input op_type op,
         input logic [SampleW-1:0] volt, input logic [SampleW-1:0] amps,
         input logic [SampleW-1:0] temp);
      monitor_report_type rep;
      fault_type          next_faults;
      logic [SampleW-1:0] volt_avg;
      logic [SampleW-1:0] amps_avg;
      logic [SampleW-1:0] temp_avg;
      logic [CountW-1:0]  trimmed;
      logic               tripped;
      logic [SampleW-1:0] tier_limit [TierCount];
      int unsigned        tier_delay [TierCount];
      rep = '0;
      if (op == OP_SAMPLE) begin
         // the first sample fills every slot and leaves the slot pointer alone
         if (!primed) begin
            foreach (volt_win[i]) begin
               volt_win[i] = volt;
               amps_win[i] = amps;
               temp_win[i] = temp;
            end
         end else begin
            volt_win[slot] = volt;
            amps_win[slot] = amps;
            temp_win[slot] = temp;
            slot = slot + 1'b1;
         end
         primed = 1'b1;
         volt_avg = window_mean(volt_win);
         amps_avg = window_mean(amps_win);
         temp_avg = window_mean(temp_win);
         next_faults = '0;

         if (volt_avg < limit_reg[CSR_VOLT_LOW]) begin
            next_faults.low_volt = 1'b1;
            if (countdown > CountW'(DELAY_TIER_THREE)) countdown = CountW'(DELAY_TIER_THREE);
         end else begin
            countdown = held_countdown;
         end
         held_countdown = countdown;

         tier_limit = '{limit_reg[CSR_CUR_ONE], limit_reg[CSR_CUR_TWO],
                        limit_reg[CSR_CUR_THREE], limit_reg[CSR_CUR_FOUR]};
         tier_delay = '{DELAY_TIER_ONE, DELAY_TIER_TWO, DELAY_TIER_THREE, DELAY_TIER_FOUR};
         trimmed = countdown;
         tripped = 1'b0;
         for (int n = 0; n < TierCount; n++) begin
            if (amps_avg > tier_limit[n]) begin
               next_faults.tiers[n] = 1'b1;
               tripped = 1'b1;
               if (trimmed > CountW'(tier_delay[n])) trimmed = CountW'(tier_delay[n]);
            end
         end
         if (amps_avg > limit_reg[CSR_CUR_SHORT]) begin
            next_faults.short_circuit = 1'b1;
            tripped = 1'b1;
            if (trimmed > CountW'(DELAY_SHORT)) trimmed = CountW'(DELAY_SHORT);
         end
         // nothing tripped: fall back to the value held from the voltage check
         countdown = tripped ? trimmed : held_countdown;
         held_countdown = countdown;

         if (temp_avg < limit_reg[CSR_TEMP_TRIP]) begin
            next_faults.over_temp = (hot_run > HotConfirm) ? 1'b1 : faults.over_temp;
            if (hot_run != HotMax) hot_run = hot_run + 1'b1;
         end else begin
            hot_run = '0;
         end
         faults = next_faults;
      end else begin
         countdown = countdown - ManageStep;
         if (countdown == '0) begin
            countdown = ReloadValue;
            rep.stop = 1'b1;
         end
         if (faults != '0) rep.stop = 1'b1;
      end
      rep.low_volt      = faults.low_volt;
      rep.tiers         = faults.tiers;
      rep.short_circuit = faults.short_circuit;
      rep.over_temp     = faults.over_temp;
      rep.countdown     = countdown;
      return rep;
   endfunction

   function automatic void compare_field(input string field, input logic [CountW-1:0] want,
         input logic [CountW-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : watch
      monitor_report_type want;
      if (reset) begin
         foreach (volt_win[i]) begin
            volt_win[i] = '0;
            amps_win[i] = '0;
            temp_win[i] = '0;
         end
         slot = '0;
         primed = 1'b0;
         faults = '0;
         hot_run = '0;
         countdown = CountIdle;
         held_countdown = CountIdle;
         foreach (limit_reg[i]) limit_reg[i] = LimitTop;
         limit_reg[CSR_VOLT_LOW] = '0;
         limit_reg[CSR_TEMP_TRIP] = '0;
         awaited_reports.delete();
      end else begin
         if (csr_write_en && csr_index != CSR_UNUSED) limit_reg[csr_index] = csr_data;
         if (req_valid && !req_stall) begin
            awaited_reports.push_back(predict_protection(op_type'(req_op), req_volt_sample,
                                                         req_current_sample, req_temp_sample));
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_reports.size() == 0) begin
               $display("%0t: result with no request waiting, countdown %0h", $time,
                        rsp_protect_countdown);
               errors++;
            end else begin
               want = awaited_reports.pop_front();
               compare_field("low_volt_flag", CountW'(want.low_volt), CountW'(rsp_low_volt_flag));
               compare_field("over_cur_tiers", CountW'(want.tiers), CountW'(rsp_over_cur_tiers));
               compare_field("short_flag", CountW'(want.short_circuit), CountW'(rsp_short_flag));
               compare_field("over_temp_flag", CountW'(want.over_temp),
                             CountW'(rsp_over_temp_flag));
               compare_field("protect_countdown", want.countdown, rsp_protect_countdown);
               compare_field("stop_request", CountW'(want.stop), CountW'(rsp_stop_request));
               checked++;
            end
         end
      end
      mismatch_count  <= errors;
      pending_results <= awaited_reports.size();
      results_checked <= checked;
   end

endmodule : tmpm_protection_checker

// ===== bench/tiered_motor_protection_monitor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiered_motor_protection_monitor_test
// Drives limit writes and sample and manage requests into the protection
// monitor under several idle and stall patterns; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tiered_motor_protection_monitor_test;
   import tmpm_pkg::*;

   localparam int unsigned DelayTierOne   = 3000;
   localparam int unsigned DelayTierTwo   = 600;
   localparam int unsigned DelayTierThree = 100;
   localparam int unsigned DelayTierFour  = 20;
   localparam int unsigned DelayShort     = 10;
   localparam int unsigned PhaseCount     = 8;
   localparam int unsigned PhaseItems     = 150;
   localparam int unsigned HoldOffCycles  = 160;
   localparam int unsigned QuietLimit     = 4000;
   localparam int unsigned DrainCycles    = 4;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_en = 1'b0;
   logic [CsrIndexW-1:0] csr_index = '0;
   logic [SampleW-1:0]   csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_op = 1'b0;
   logic [SampleW-1:0]   req_volt_sample = '0;
   logic [SampleW-1:0]   req_current_sample = '0;
   logic [SampleW-1:0]   req_temp_sample = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_low_volt_flag;
   logic [TierCount-1:0] rsp_over_cur_tiers;
   logic                 rsp_short_flag;
   logic                 rsp_over_temp_flag;
   logic [CountW-1:0]    rsp_protect_countdown;
   logic                 rsp_stop_request;

   int                   mismatch_count;
   int                   pending_results;
   int                   results_checked;
   int unsigned          idle_pct = 0;
   int unsigned          stall_pct = 0;
   logic                 hold_ask = 1'b0;
   logic                 hold_seen = 1'b0;
   int unsigned          hold_left = 0;
   int unsigned          quiet_cycles = 0;
   int unsigned          requests_sent = 0;
   int unsigned          manage_sent = 0;
   int unsigned          limit_writes = 0;
   logic [SampleW-1:0]   lim [FlagCount];

   tiered_motor_protection_monitor #(
      .DELAY_TIER_ONE   (DelayTierOne),
      .DELAY_TIER_TWO   (DelayTierTwo),
      .DELAY_TIER_THREE (DelayTierThree),
      .DELAY_TIER_FOUR  (DelayTierFour),
      .DELAY_SHORT      (DelayShort)
   ) u_dut (
      .clock, .reset, .csr_write_en, .csr_index, .csr_data,
      .req_valid, .req_stall, .req_op, .req_volt_sample, .req_current_sample,
      .req_temp_sample, .rsp_valid, .rsp_stall, .rsp_low_volt_flag, .rsp_over_cur_tiers,
      .rsp_short_flag, .rsp_over_temp_flag, .rsp_protect_countdown, .rsp_stop_request
   );

   tmpm_protection_checker #(
      .DELAY_TIER_ONE   (DelayTierOne),
      .DELAY_TIER_TWO   (DelayTierTwo),
      .DELAY_TIER_THREE (DelayTierThree),
      .DELAY_TIER_FOUR  (DelayTierFour),
      .DELAY_SHORT      (DelayShort)
   ) u_checker (
      .clock, .reset, .csr_write_en, .csr_index, .csr_data,
      .req_valid, .req_stall, .req_op, .req_volt_sample, .req_current_sample,
      .req_temp_sample, .rsp_valid, .rsp_stall, .rsp_low_volt_flag, .rsp_over_cur_tiers,
      .rsp_short_flag, .rsp_over_temp_flag, .rsp_protect_countdown, .rsp_stop_request,
      .mismatch_count, .pending_results, .results_checked
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_left <= HoldOffCycles;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input op_type op, input logic [SampleW-1:0] volt,
         input logic [SampleW-1:0] amps, input logic [SampleW-1:0] temp);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= op;
      req_volt_sample    <= volt;
      req_current_sample <= amps;
      req_temp_sample    <= temp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      if (op == OP_MANAGE) manage_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic load_limits(input logic [SampleW-1:0] volt_low,
         input logic [SampleW-1:0] one, input logic [SampleW-1:0] two,
         input logic [SampleW-1:0] three, input logic [SampleW-1:0] four,
         input logic [SampleW-1:0] short_lim, input logic [SampleW-1:0] temp_lim);
      csr_index_type idx;
      lim = '{volt_low, one, two, three, four, short_lim, temp_lim};
      idx = CSR_VOLT_LOW;
      repeat (FlagCount) begin
         csr_write_en <= 1'b1;
         csr_index    <= idx;
         csr_data     <= lim[idx];
         @(posedge clock);
         idx = idx.next();
      end
      // the spare index must be ignored
      csr_index <= CSR_UNUSED;
      csr_data  <= SampleW'($urandom);
      @(posedge clock);
      csr_write_en <= 1'b0;
      limit_writes += FlagCount + 1;
   endtask

   // mostly readings close to a limit or repeated, so averages sit on the edge
   function automatic logic [SampleW-1:0] sample_near(input logic [SampleW-1:0] centre);
      int v;
      case ($urandom_range(3))
         0: v = $urandom_range(int'(LimitTop));
         1: v = int'(centre) + int'($urandom_range(128)) - 64;
         2: v = $urandom_range(1) ? int'(LimitTop) : 0;
         default: v = int'(centre);
      endcase
      if (v < 0) v = 0;
      if (v > int'(LimitTop)) v = int'(LimitTop);
      return SampleW'(v);
   endfunction

   task automatic run_random(input int unsigned count);
      int unsigned done;
      int unsigned burst;
      int unsigned pick;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            send_request(OP_SAMPLE, sample_near(lim[CSR_VOLT_LOW]),
                         sample_near(lim[$urandom_range(CSR_CUR_ONE, CSR_CUR_SHORT)]),
                         sample_near(lim[CSR_TEMP_TRIP]));
            done++;
         end else begin
            burst = 1;
            // runs of manage ticks let the countdown run out
            if (pick >= 85) begin
               burst = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 2);
            end
            repeat (burst) begin
               send_request(OP_MANAGE, SampleW'($urandom), SampleW'($urandom),
                            SampleW'($urandom));
            end
            done += burst;
         end
      end
   endtask

   initial begin
      logic [SampleW-1:0] cur_levels [$];
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      load_limits(12'd2048, 12'd1000, 12'd2000, 12'd3000, 12'd3500, 12'd4000, 12'd1000);
      // manage tick before any sample
      send_request(OP_MANAGE, '1, '1, '1);
      // first sample primes all windows: low voltage, every tier and short trip
      send_request(OP_SAMPLE, '0, '1, '0);
      // countdown runs down to zero, reloads and expires again
      repeat (6) send_request(OP_MANAGE, '0, '0, '0);
      // cold thermistor run: over temperature confirms, then the count saturates
      repeat (8) send_request(OP_SAMPLE, '1, '0, '0);
      // averages exactly on the current and temperature limits
      send_request(OP_SAMPLE, '1, 12'd4000, 12'd4000);
      send_request(OP_SAMPLE, '1, '1, '1);
      repeat (2) send_request(OP_MANAGE, SampleW'($urandom), SampleW'($urandom), '0);
      wait_for_results();

      for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
         if (phase == 0) begin
            load_limits('0, '0, '0, '0, '0, '0, '0);
         end else if (phase == 1) begin
            load_limits('1, '1, '1, '1, '1, '1, '1);
         end else begin
            cur_levels.delete();
            repeat (TierCount + 1) cur_levels.push_back(SampleW'($urandom));
            if ($urandom_range(1)) cur_levels.sort();
            load_limits(SampleW'($urandom), cur_levels[0], cur_levels[1], cur_levels[2],
                        cur_levels[3], cur_levels[4], SampleW'($urandom));
         end
         case (phase % 4)
            0: begin
               idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct = 50;
               stall_pct <= 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct <= 50;
            end
            default: begin
               idle_pct = 17;
               stall_pct <= 17;
            end
         endcase
         // long receiver hold-off while requests keep coming, so the block backs up
         if (phase == 0) hold_ask <= ~hold_ask;
         repeat (2) begin
            run_random(PhaseItems / 2);
            wait_for_results();
         end
      end

      repeat (DrainCycles) @(posedge clock);
      $display("run covered %0d requests (%0d manage ticks) and %0d limit writes over %0d phases",
               requests_sent, manage_sent, limit_writes, PhaseCount);
      $display("%0d results compared, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule : tiered_motor_protection_monitor_test

// ===== tiered_motor_protection_monitor.f =====
hdl/tmpm_pkg.sv
hdl/tiered_motor_protection_monitor.sv
bench/tmpm_protection_checker.sv
bench/tiered_motor_protection_monitor_test.sv
